FILE: design/spcp_pkg.sv
// ============================================================================
// spcp_pkg: shared types and constants for the segment pair closest points
// Coordinate, dot product and quotient widths, the item structs and the
// payload that travels alongside each item down the pipeline.
// ============================================================================
package spcp_pkg;

    // Fixed point formats.
    localparam int COORD_FRAC_BITS = 16;
    localparam int PARAM_FRAC_BITS = 16;

    // Datapath widths.
    localparam int COORD_W   = 32;
    localparam int DIR_W     = COORD_W + 1;
    localparam int SQ_W      = 2 * DIR_W;
    localparam int DOT_W     = SQ_W + 2;
    localparam int HALF_W    = DOT_W / 2;
    localparam int PROD_W    = 2 * DOT_W;
    localparam int DIV_W     = PROD_W + 2;
    localparam int T_W       = PARAM_FRAC_BITS + 1;
    localparam int NB_W      = DOT_W + T_W + 1;
    localparam int DIV_STEPS = PARAM_FRAC_BITS;

    // Configuration port.
    localparam int THR_W  = 16;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic [ADDR_W-3:0] REG_THR = '0;
    localparam logic [THR_W-1:0]  THR_RESET = THR_W'(7);

    // Parameter constants.
    localparam logic [T_W-1:0] T_ONE = {1'b1, {PARAM_FRAC_BITS{1'b0}}};
    localparam logic [T_W-1:0] T_HALF = T_ONE >> 1;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIR_W-1:0]   dir_t;
    typedef logic signed [SQ_W-1:0]    sq_t;
    typedef logic signed [DOT_W-1:0]   dot_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [DIV_W-1:0]   dwide_t;
    typedef logic signed [NB_W-1:0]    nb_t;
    typedef logic [T_W-1:0]            tpar_t;

    // How the second quotient is used to form the two segment parameters.
    typedef enum logic [2:0] {
        SEL_NONE,
        SEL_TB,
        SEL_TA_B0,
        SEL_TA_B1,
        SEL_TB_KEEP
    } sel_t;

    typedef struct packed {
        coord_t a_start_x;
        coord_t a_start_y;
        coord_t a_start_z;
        coord_t a_end_x;
        coord_t a_end_y;
        coord_t a_end_z;
        coord_t b_start_x;
        coord_t b_start_y;
        coord_t b_start_z;
        coord_t b_end_x;
        coord_t b_end_y;
        coord_t b_end_z;
    } in_item_t;

    typedef struct packed {
        coord_t near_a_x;
        coord_t near_a_y;
        coord_t near_a_z;
        coord_t near_b_x;
        coord_t near_b_y;
        coord_t near_b_z;
    } out_item_t;

    // Per-item payload carried alongside the arithmetic.
    typedef struct packed {
        coord_t [2:0] sa;
        dir_t [2:0]   da;
        coord_t [2:0] sb;
        dir_t [2:0]   db;
        dot_t         la;
        dot_t         lb;
        dot_t         pa;
        dot_t         pb;
        dot_t         d;
        logic         deg_a;
        logic         deg_b;
        tpar_t        ta0;
        sel_t         sel;
    } side_t;

endpackage

FILE: design/spcp_if.sv
// ============================================================================
// spcp_if: item channels of the segment pair closest points block
// A valid/ready channel for segment pairs and one for closest point pairs.
// ============================================================================
interface spcp_in_if;
    import spcp_pkg::*;

    logic     valid;
    logic     ready;
    in_item_t item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

interface spcp_out_if;
    import spcp_pkg::*;

    logic      valid;
    logic      ready;
    out_item_t item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

FILE: design/spcp_front.sv
// ============================================================================
// spcp_front: direction vectors, dot products and the first quotient operands
// Eight stages: differences, 33x33 products, dot sums, split wide products
// in three steps, then the denominator and numerator for the A parameter.
// ============================================================================
module spcp_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  spcp_pkg::in_item_t        in_item,
    input  logic [spcp_pkg::THR_W-1:0] thr,
    output logic                      out_valid,
    output spcp_pkg::side_t           out_side,
    output spcp_pkg::dwide_t          out_num,
    output spcp_pkg::dwide_t          out_den
);
    import spcp_pkg::*;

    function automatic dot_t sum3(input sq_t x0, input sq_t x1, input sq_t x2);
        return DOT_W'(x0) + DOT_W'(x1) + DOT_W'(x2);
    endfunction

    logic [7:0] vld_reg;

    coord_t a_s [3];
    coord_t a_e [3];
    coord_t b_s [3];
    coord_t b_e [3];

    side_t s1_side_next, s1_side_reg;
    dir_t  s1_r_reg [3];

    side_t s2_side_reg;
    sq_t   s2_aa_reg [3];
    sq_t   s2_bb_reg [3];
    sq_t   s2_ar_reg [3];
    sq_t   s2_br_reg [3];
    sq_t   s2_ab_reg [3];

    side_t s3_side_next, s3_side_reg;

    dot_t  ma [4];
    dot_t  mb [4];
    dot_t  thr_l;
    side_t s4_side_next, s4_side_reg;
    logic [2*HALF_W-1:0]        s4_ll_reg [4];
    logic signed [2*HALF_W:0]   s4_lh_reg [4];
    logic signed [2*HALF_W:0]   s4_hl_reg [4];
    logic signed [2*HALF_W-1:0] s4_hh_reg [4];

    side_t s5_side_reg;
    logic signed [2*HALF_W+1:0] s5_mid_reg [4];
    prod_t s5_lohi_reg [4];

    side_t s6_side_reg;
    prod_t s6_prod_reg [4];

    side_t  s7_side_reg;
    dwide_t s7_den_reg, s7_num_reg;

    dwide_t thr_d;
    side_t  s8_side_reg;
    dwide_t s8_den_reg, s8_num_reg;

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[6:0], in_valid};
    end

    // Stage 1: unpack the item and form the difference vectors.
    assign a_s[0] = in_item.a_start_x;
    assign a_s[1] = in_item.a_start_y;
    assign a_s[2] = in_item.a_start_z;
    assign a_e[0] = in_item.a_end_x;
    assign a_e[1] = in_item.a_end_y;
    assign a_e[2] = in_item.a_end_z;
    assign b_s[0] = in_item.b_start_x;
    assign b_s[1] = in_item.b_start_y;
    assign b_s[2] = in_item.b_start_z;
    assign b_e[0] = in_item.b_end_x;
    assign b_e[1] = in_item.b_end_y;
    assign b_e[2] = in_item.b_end_z;

    always_comb
    begin
        s1_side_next = '0;
        for (int k = 0; k < 3; k++)
        begin
            s1_side_next.sa[k] = a_s[k];
            s1_side_next.sb[k] = b_s[k];
            s1_side_next.da[k] = DIR_W'(a_e[k]) - DIR_W'(a_s[k]);
            s1_side_next.db[k] = DIR_W'(b_e[k]) - DIR_W'(b_s[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_side_reg <= s1_side_next;
            for (int k = 0; k < 3; k++)
                s1_r_reg[k] <= DIR_W'(a_s[k]) - DIR_W'(b_s[k]);
        end
    end

    // Stage 2: the fifteen component products.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_side_reg <= s1_side_reg;
            for (int k = 0; k < 3; k++)
            begin
                s2_aa_reg[k] <= $signed(s1_side_reg.da[k]) * $signed(s1_side_reg.da[k]);
                s2_bb_reg[k] <= $signed(s1_side_reg.db[k]) * $signed(s1_side_reg.db[k]);
                s2_ar_reg[k] <= $signed(s1_side_reg.da[k]) * $signed(s1_r_reg[k]);
                s2_br_reg[k] <= $signed(s1_side_reg.db[k]) * $signed(s1_r_reg[k]);
                s2_ab_reg[k] <= $signed(s1_side_reg.da[k]) * $signed(s1_side_reg.db[k]);
            end
        end
    end

    // Stage 3: dot products.
    always_comb
    begin
        s3_side_next    = s2_side_reg;
        s3_side_next.la = sum3(s2_aa_reg[0], s2_aa_reg[1], s2_aa_reg[2]);
        s3_side_next.lb = sum3(s2_bb_reg[0], s2_bb_reg[1], s2_bb_reg[2]);
        s3_side_next.pa = sum3(s2_ar_reg[0], s2_ar_reg[1], s2_ar_reg[2]);
        s3_side_next.pb = sum3(s2_br_reg[0], s2_br_reg[1], s2_br_reg[2]);
        s3_side_next.d  = sum3(s2_ab_reg[0], s2_ab_reg[1], s2_ab_reg[2]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            s3_side_reg <= s3_side_next;
    end

    // Stage 4: point tests and half-width partial products of the four
    // wide products LA*LB, D*D, D*PB and PA*LB.
    assign thr_l = dot_t'({thr, {COORD_FRAC_BITS{1'b0}}});

    assign ma[0] = s3_side_reg.la;
    assign mb[0] = s3_side_reg.lb;
    assign ma[1] = s3_side_reg.d;
    assign mb[1] = s3_side_reg.d;
    assign ma[2] = s3_side_reg.d;
    assign mb[2] = s3_side_reg.pb;
    assign ma[3] = s3_side_reg.pa;
    assign mb[3] = s3_side_reg.lb;

    always_comb
    begin
        s4_side_next       = s3_side_reg;
        s4_side_next.deg_a = $signed(s3_side_reg.la) <= thr_l;
        s4_side_next.deg_b = $signed(s3_side_reg.lb) <= thr_l;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_side_reg <= s4_side_next;
            for (int j = 0; j < 4; j++)
            begin
                s4_ll_reg[j] <= ma[j][HALF_W-1:0] * mb[j][HALF_W-1:0];
                s4_lh_reg[j] <= $signed({1'b0, ma[j][HALF_W-1:0]})
                              * $signed(mb[j][DOT_W-1:HALF_W]);
                s4_hl_reg[j] <= $signed(ma[j][DOT_W-1:HALF_W])
                              * $signed({1'b0, mb[j][HALF_W-1:0]});
                s4_hh_reg[j] <= $signed(ma[j][DOT_W-1:HALF_W])
                              * $signed(mb[j][DOT_W-1:HALF_W]);
            end
        end
    end

    // Stage 5: cross terms summed, outer terms placed side by side.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_side_reg <= s4_side_reg;
            for (int j = 0; j < 4; j++)
            begin
                s5_mid_reg[j]  <= $signed(s4_lh_reg[j]) + $signed(s4_hl_reg[j]);
                s5_lohi_reg[j] <= {s4_hh_reg[j], s4_ll_reg[j]};
            end
        end
    end

    // Stage 6: full wide products.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s6_side_reg <= s5_side_reg;
            for (int j = 0; j < 4; j++)
                s6_prod_reg[j] <= s5_lohi_reg[j] + (PROD_W'(s5_mid_reg[j]) <<< HALF_W);
        end
    end

    // Stage 7: denominator and numerator of the A parameter.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s7_side_reg <= s6_side_reg;
            s7_den_reg  <= DIV_W'(s6_prod_reg[0]) - DIV_W'(s6_prod_reg[1]);
            s7_num_reg  <= DIV_W'(s6_prod_reg[2]) - DIV_W'(s6_prod_reg[3]);
        end
    end

    // Stage 8: near-parallel segments get a zero numerator, so tA starts at 0.
    assign thr_d = dwide_t'({thr, {3*COORD_FRAC_BITS{1'b0}}});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s8_side_reg <= s7_side_reg;
            s8_den_reg  <= s7_den_reg;
            s8_num_reg  <= (s7_den_reg > thr_d) ? s7_num_reg : '0;
        end
    end

    assign out_valid = vld_reg[7];
    assign out_side  = s8_side_reg;
    assign out_num   = s8_num_reg;
    assign out_den   = s8_den_reg;

endmodule

FILE: design/spcp_div.sv
// ============================================================================
// spcp_div: pipelined clamped fraction divider
// One setup stage settles the clamped cases, then one restoring step per
// quotient bit, each in its own register stage.
// ============================================================================
module spcp_div (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  spcp_pkg::dwide_t in_num,
    input  spcp_pkg::dwide_t in_den,
    input  spcp_pkg::side_t  in_side,
    output logic             out_valid,
    output spcp_pkg::tpar_t  out_q,
    output spcp_pkg::side_t  out_side
);
    import spcp_pkg::*;

    logic   vld_reg  [DIV_STEPS+1];
    logic   done_reg [DIV_STEPS+1];
    dwide_t rem_reg  [DIV_STEPS+1];
    dwide_t den_reg  [DIV_STEPS+1];
    tpar_t  q_reg    [DIV_STEPS+1];
    side_t  side_reg [DIV_STEPS+1];

    logic  done_next;
    tpar_t q_next;

    // Setup: a non-positive divisor or numerator gives 0, a numerator at
    // or above the divisor gives 1.0, anything else is divided bit by bit.
    always_comb
    begin
        priority if (in_den <= 0 || in_num <= 0)
        begin
            done_next = 1'b1;
            q_next    = '0;
        end
        else if (in_num >= in_den)
        begin
            done_next = 1'b1;
            q_next    = T_ONE;
        end
        else
        begin
            done_next = 1'b0;
            q_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (en)
            vld_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            done_reg[0] <= done_next;
            q_reg[0]    <= q_next;
            rem_reg[0]  <= in_num;
            den_reg[0]  <= in_den;
            side_reg[0] <= in_side;
        end
    end

    // One quotient bit per stage.
    for (genvar i = 1; i <= DIV_STEPS; i++)
    begin : g_step
        dwide_t r2;
        logic   ge;

        always_comb
        begin
            r2 = rem_reg[i-1] <<< 1;
            ge = r2 >= den_reg[i-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i] <= 1'b0;
            else if (en)
                vld_reg[i] <= vld_reg[i-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                done_reg[i] <= done_reg[i-1];
                den_reg[i]  <= den_reg[i-1];
                side_reg[i] <= side_reg[i-1];
                if (done_reg[i-1])
                begin
                    rem_reg[i] <= rem_reg[i-1];
                    q_reg[i]   <= q_reg[i-1];
                end
                else
                begin
                    rem_reg[i] <= ge ? (r2 - den_reg[i-1]) : r2;
                    q_reg[i]   <= {q_reg[i-1][T_W-2:0], ge};
                end
            end
        end
    end

    assign out_valid = vld_reg[DIV_STEPS];
    assign out_q     = q_reg[DIV_STEPS];
    assign out_side  = side_reg[DIV_STEPS];

endmodule

FILE: design/spcp_mid.sv
// ============================================================================
// spcp_mid: B parameter numerator and choice of the second division
// Forms D*tA + PB*2^F over three stages, then picks the case and the
// operands of the division that settles the final parameters.
// ============================================================================
module spcp_mid (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  spcp_pkg::tpar_t  in_q,
    input  spcp_pkg::side_t  in_side,
    output logic             out_valid,
    output spcp_pkg::side_t  out_side,
    output spcp_pkg::dwide_t out_num,
    output spcp_pkg::dwide_t out_den
);
    import spcp_pkg::*;

    logic [3:0] vld_reg;

    side_t s1_side_next, s1_side_reg;
    logic [HALF_W+T_W-1:0]               s1_dl_reg;
    logic signed [DOT_W-HALF_W+T_W:0]    s1_dh_reg;

    side_t s2_side_reg;
    nb_t   s2_prod_reg;

    side_t s3_side_reg;
    nb_t   s3_nb_reg;

    nb_t    lbs;
    side_t  s4_side_next, s4_side_reg;
    dwide_t s4_num_next, s4_num_reg;
    dwide_t s4_den_next, s4_den_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[2:0], in_valid};
    end

    // Stage 1: partial products of D * tA.
    always_comb
    begin
        s1_side_next     = in_side;
        s1_side_next.ta0 = in_q;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_side_reg <= s1_side_next;
            s1_dl_reg   <= in_side.d[HALF_W-1:0] * in_q;
            s1_dh_reg   <= $signed(in_side.d[DOT_W-1:HALF_W]) * $signed({1'b0, in_q});
        end
    end

    // Stage 2: D * tA.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_side_reg <= s1_side_reg;
            s2_prod_reg <= (NB_W'(s1_dh_reg) <<< HALF_W) + $signed(NB_W'(s1_dl_reg));
        end
    end

    // Stage 3: numerator of tB at the scale of LB * 2^F.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_side_reg <= s2_side_reg;
            s3_nb_reg   <= s2_prod_reg + (NB_W'(s2_side_reg.pb) <<< PARAM_FRAC_BITS);
        end
    end

    // Stage 4: pick the case and the second division.
    assign lbs = NB_W'(s3_side_reg.lb) <<< PARAM_FRAC_BITS;

    always_comb
    begin
        s4_side_next = s3_side_reg;
        priority if (s3_side_reg.deg_a && s3_side_reg.deg_b)
        begin
            s4_side_next.sel = SEL_NONE;
            s4_num_next      = '0;
            s4_den_next      = '0;
        end
        else if (s3_side_reg.deg_a)
        begin
            s4_side_next.sel = SEL_TB;
            s4_num_next      = DIV_W'(s3_side_reg.pb);
            s4_den_next      = DIV_W'(s3_side_reg.lb);
        end
        else if (s3_side_reg.deg_b || s3_nb_reg < 0)
        begin
            // Point B, or tB below zero: tB is 0 and tA follows from B's start.
            s4_side_next.sel = SEL_TA_B0;
            s4_num_next      = -DIV_W'(s3_side_reg.pa);
            s4_den_next      = DIV_W'(s3_side_reg.la);
        end
        else if (s3_nb_reg > lbs)
        begin
            s4_side_next.sel = SEL_TA_B1;
            s4_num_next      = DIV_W'(s3_side_reg.d) - DIV_W'(s3_side_reg.pa);
            s4_den_next      = DIV_W'(s3_side_reg.la);
        end
        else
        begin
            s4_side_next.sel = SEL_TB_KEEP;
            s4_num_next      = DIV_W'(s3_nb_reg);
            s4_den_next      = DIV_W'(lbs);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_side_reg <= s4_side_next;
            s4_num_reg  <= s4_num_next;
            s4_den_reg  <= s4_den_next;
        end
    end

    assign out_valid = vld_reg[3];
    assign out_side  = s4_side_reg;
    assign out_num   = s4_num_reg;
    assign out_den   = s4_den_reg;

endmodule

FILE: design/spcp_place.sv
// ============================================================================
// spcp_place: final parameters and the closest points
// Selects tA and tB, multiplies each direction by its parameter, then
// rounds to nearest with ties up and adds the start point.
// ============================================================================
module spcp_place (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  spcp_pkg::tpar_t     in_q,
    input  spcp_pkg::side_t     in_side,
    output logic                out_valid,
    output spcp_pkg::out_item_t out_item
);
    import spcp_pkg::*;

    localparam int PR_W = DIR_W + T_W + 1;

    logic [1:0] vld_reg;
    tpar_t ta, tb;

    logic signed [PR_W-1:0] pa_reg [3];
    logic signed [PR_W-1:0] pb_reg [3];
    coord_t sa_reg [3];
    coord_t sb_reg [3];

    logic signed [PR_W-1:0] ra [3];
    logic signed [PR_W-1:0] rb [3];
    coord_t near_a [3];
    coord_t near_b [3];
    out_item_t item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[0], in_valid};
    end

    // Final parameter pair for each case.
    always_comb
    begin
        unique case (in_side.sel)
            SEL_NONE:
            begin
                ta = '0;
                tb = '0;
            end
            SEL_TB:
            begin
                ta = '0;
                tb = in_q;
            end
            SEL_TA_B0:
            begin
                ta = in_q;
                tb = '0;
            end
            SEL_TA_B1:
            begin
                ta = in_q;
                tb = T_ONE;
            end
            SEL_TB_KEEP:
            begin
                ta = in_side.ta0;
                tb = in_q;
            end
            default:
            begin
                ta = '0;
                tb = '0;
            end
        endcase
    end

    // Stage 1: direction times parameter.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                pa_reg[k] <= $signed(in_side.da[k]) * $signed({1'b0, ta});
                pb_reg[k] <= $signed(in_side.db[k]) * $signed({1'b0, tb});
                sa_reg[k] <= in_side.sa[k];
                sb_reg[k] <= in_side.sb[k];
            end
        end
    end

    // Stage 2: round, floor by the fraction and offset from the start.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            ra[k] = (pa_reg[k] + $signed(PR_W'(T_HALF))) >>> PARAM_FRAC_BITS;
            rb[k] = (pb_reg[k] + $signed(PR_W'(T_HALF))) >>> PARAM_FRAC_BITS;
            near_a[k] = sa_reg[k] + ra[k][COORD_W-1:0];
            near_b[k] = sb_reg[k] + rb[k][COORD_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg.near_a_x <= near_a[0];
            item_reg.near_a_y <= near_a[1];
            item_reg.near_a_z <= near_a[2];
            item_reg.near_b_x <= near_b[0];
            item_reg.near_b_y <= near_b[1];
            item_reg.near_b_z <= near_b[2];
        end
    end

    assign out_valid = vld_reg[1];
    assign out_item  = item_reg;

endmodule

FILE: design/segment_pair_closest_points.sv
// ============================================================================
// segment_pair_closest_points: closest points between two 3D segments
// Streams segment pairs in, closest point pairs out, one item per cycle when not stalled.
// ============================================================================
// Usage:
//   seg_in carries the four end points of segments A and B, signed Q16.16.
//   pts_out carries the closest point on A and on B, signed Q16.16.
//   The APB port holds one register, the degenerate threshold (byte 0);
//   write it only while no item is in flight.
// Path: a result is valid once its item has passed the products and dot
//   sums, two dividers (one setup stage plus one quotient bit per stage),
//   the B numerator and case selection between them and the stages that
//   place the points and register them.
// Throughput: one item per cycle while pts_out takes them, set by the fully pipelined dividers.
// Stall: the whole pipeline advances together; a two-entry output buffer
//   absorbs the item that arrives when pts_out first stalls, and seg_in
//   ready drops once that buffer is full.
// Reset: clears all valid bits and the buffer and sets the threshold to 7.
// ============================================================================
module segment_pair_closest_points (
    input  logic                        clk,
    input  logic                        rst_n,
    spcp_in_if.sink                     seg_in,
    spcp_out_if.source                  pts_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [spcp_pkg::ADDR_W-1:0] paddr,
    input  logic [spcp_pkg::DATA_W-1:0] pwdata,
    output logic [spcp_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import spcp_pkg::*;

    logic [THR_W-1:0] thr_reg;
    logic             cfg_write;
    logic             en;

    logic   f_valid;
    side_t  f_side;
    dwide_t f_num, f_den;

    logic   d1_valid;
    tpar_t  d1_q;
    side_t  d1_side;

    logic   m_valid;
    side_t  m_side;
    dwide_t m_num, m_den;

    logic   d2_valid;
    tpar_t  d2_q;
    side_t  d2_side;

    logic      p_valid;
    out_item_t p_item;

    logic      out_valid_reg, skid_valid_reg;
    out_item_t out_item_reg, skid_item_reg;
    logic      out_fire;

    // Configuration register.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[ADDR_W-1:2] == REG_THR) ? DATA_W'(thr_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= THR_RESET;
        else if (cfg_write && paddr[ADDR_W-1:2] == REG_THR)
            thr_reg <= pwdata[THR_W-1:0];
    end

    // The pipeline moves whenever the output buffer has room.
    assign en           = !skid_valid_reg;
    assign seg_in.ready = en;

    spcp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (seg_in.valid),
        .in_item   (seg_in.item),
        .thr       (thr_reg),
        .out_valid (f_valid),
        .out_side  (f_side),
        .out_num   (f_num),
        .out_den   (f_den)
    );

    spcp_div u_div_a (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_valid),
        .in_num    (f_num),
        .in_den    (f_den),
        .in_side   (f_side),
        .out_valid (d1_valid),
        .out_q     (d1_q),
        .out_side  (d1_side)
    );

    spcp_mid u_mid (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (d1_valid),
        .in_q      (d1_q),
        .in_side   (d1_side),
        .out_valid (m_valid),
        .out_side  (m_side),
        .out_num   (m_num),
        .out_den   (m_den)
    );

    spcp_div u_div_b (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (m_valid),
        .in_num    (m_num),
        .in_den    (m_den),
        .in_side   (m_side),
        .out_valid (d2_valid),
        .out_q     (d2_q),
        .out_side  (d2_side)
    );

    spcp_place u_place (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (d2_valid),
        .in_q      (d2_q),
        .in_side   (d2_side),
        .out_valid (p_valid),
        .out_item  (p_item)
    );

    // Output register with a skid entry behind it.
    assign out_fire = out_valid_reg && pts_out.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_fire || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
                out_valid_reg <= p_valid;
        end
        else if (p_valid && en)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (out_fire || !out_valid_reg)
            out_item_reg <= skid_valid_reg ? skid_item_reg : p_item;
        else if (en)
            skid_item_reg <= p_item;
    end

    assign pts_out.valid = out_valid_reg;
    assign pts_out.item  = out_item_reg;

    // The skid entry is only ever filled behind a held output item.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds an item while the output register is empty");

    a_skid_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !pts_out.ready))
        else $error("skid entry filled without an output stall");

    a_thr_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_write && paddr[ADDR_W-1:2] == REG_THR) |=> thr_reg == $past(pwdata[THR_W-1:0]))
        else $error("threshold register did not take the written value");

    a_pipe_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!en && p_valid) |=> p_valid)
        else $error("pipeline output item lost during a stall");

endmodule
